>>> hw/rtl/sete_pkg.sv
`default_nettype none

package sete_pkg;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    // Top of the tile column: 512 minus one tile height
    localparam logic [9:0] SCREEN_Y_BASE = 10'd496;
    localparam logic [10:0] TILE_PITCH_X = 11'd16;

    localparam int QUEUE_DEPTH_DEF = 2;

    // One accepted sprite, ready to expand
    typedef struct packed {
        logic [14:0]        base;
        logic [5:0]         colour;
        logic               fx;
        logic               fy;
        logic [1:0]         hexp;
        logic [1:0]         wexp;
        logic signed [10:0] x_start;
        logic signed [9:0]  y_start;
    } desc_t;

    // Highest tile count index for a size exponent (count minus one)
    function automatic logic [2:0] exp_mask(input logic [1:0] e);
        exp_mask = {e == 2'd3, e[1], e != 2'd0};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sete_front.sv
`default_nettype none

module sete_front
    import sete_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic                 cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                 q_full,
    output logic                      q_push,
    output desc_t                     q_desc
);

    logic       front_pass_reg;
    logic [15:0] y_word;
    logic [15:0] tile_word;
    logic [7:0]  attr_byte;
    logic [7:0]  flip_byte;
    logic [15:0] x_word;
    logic [8:0]  y9;
    logic [8:0]  x9;
    logic        keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_pass_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            front_pass_reg <= cfg_wdata;
        end
    end

    assign y_word    = s_axis_tdata[15:0];
    assign tile_word = s_axis_tdata[31:16];
    assign attr_byte = s_axis_tdata[39:32];
    assign flip_byte = s_axis_tdata[47:40];
    assign x_word    = s_axis_tdata[63:48];

    assign y9 = y_word[8:0];
    assign x9 = x_word[8:0];

    // Drop on pass mismatch or zero position
    assign keep = (attr_byte[7] == front_pass_reg) && (x9 != 9'd0) && (y9 != 9'd0);

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && keep;

    always_comb
    begin
        q_desc.base    = tile_word[14:0];
        q_desc.colour  = attr_byte[5:0];
        q_desc.fx      = flip_byte[0];
        q_desc.fy      = flip_byte[1];
        q_desc.hexp    = y_word[10:9];
        q_desc.wexp    = y_word[12:11];
        // Flipped multi-column sprites start one tile to the right
        if (flip_byte[0] && (y_word[12:11] != 2'd0))
        begin
            q_desc.x_start = {2'b00, x9};
        end
        else
        begin
            q_desc.x_start = {2'b00, x9} - TILE_PITCH_X;
        end
        q_desc.y_start = SCREEN_Y_BASE - {1'b0, y9};
    end

endmodule

`default_nettype wire

>>> hw/rtl/sete_queue.sv
`default_nettype none

module sete_queue
    import sete_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       full,
    input  wire logic  pop,
    output logic       pop_valid,
    output desc_t      pop_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t         mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_desc  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sete_back.sv
`default_nettype none

module sete_back
    import sete_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire desc_t                 q_desc,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    desc_t                  desc_reg;
    logic signed [10:0]     x_reg;
    logic [2:0]             row_reg;
    logic [2:0]             row_next;
    logic [2:0]             col_reg;
    logic [2:0]             col_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic                   out_last_reg;

    logic                   load_ok;
    logic                   emit;
    logic                   emit_last;
    logic                   row_end;
    logic [2:0]             row_mask;
    logic [2:0]             col_mask;
    logic [2:0]             roff;
    logic [15:0]            tile;
    logic [9:0]             ty;

    assign row_mask  = exp_mask(desc_reg.hexp);
    assign col_mask  = exp_mask(desc_reg.wexp);
    assign load_ok   = !out_valid_reg || m_axis_tready;
    assign emit      = busy_reg && load_ok;
    assign row_end   = (row_reg == row_mask);
    assign emit_last = row_end && (col_reg == col_mask);

    // Take the next sprite when idle or on the final tile of this one
    assign q_pop = q_valid && (!busy_reg || (emit && emit_last));

    // Rows run bottom-up; vertical flip reverses the tile offset
    assign roff = desc_reg.fy ? row_reg : (row_mask ^ row_reg);
    assign tile = {1'b0, desc_reg.base} + {10'd0, col_reg, 3'b000} + {13'd0, roff};
    assign ty   = desc_reg.y_start - {3'b000, row_reg, 4'b0000};

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (row_end)
            begin
                row_next = 3'd0;
                col_next = col_reg + 3'd1;
            end
            else
            begin
                row_next = row_reg + 3'd1;
            end
            if (emit_last)
            begin
                busy_next = 1'b0;
                col_next  = 3'd0;
            end
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            row_next  = 3'd0;
            col_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 3'd0;
            col_reg       <= 3'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {3'b000, ty, x_reg, desc_reg.fy, desc_reg.fx,
                             desc_reg.colour, tile};
            out_last_reg <= emit_last;
        end
        if (q_pop)
        begin
            desc_reg <= q_desc;
            x_reg    <= q_desc.x_start;
        end
        else if (emit && row_end)
        begin
            x_reg <= desc_reg.fx ? (x_reg - TILE_PITCH_X) : (x_reg + TILE_PITCH_X);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!busy_reg || (emit && emit_last)))
        else $error("descriptor taken while a sprite is still expanding");

    a_emit_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("tile command produced without a sprite loaded");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((row_reg & ~row_mask) == 3'd0 && (col_reg & ~col_mask) == 3'd0))
        else $error("row or column counter beyond sprite size");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (row_reg == 3'd0 && col_reg == 3'd0))
        else $error("counters not cleared after final tile");

endmodule

`default_nettype wire

>>> hw/rtl/sprite_entry_tile_expander.sv
// Sprite entry tile expander. Each accepted transaction on the s_axis side is
// one sprite attribute entry; the block turns it into a run of 16x16 tile draw
// commands on the m_axis side, with tlast high on the final command of the
// entry. An entry whose priority bit (attr bit 7) differs from the front_pass
// register, or whose 9-bit x or y is zero, is dropped and yields nothing. A
// kept entry of 2^w columns by 2^h rows yields 2^(w+h) commands (1 to 64),
// one per cycle out of the tile sequencer while m_axis_tready allows, columns
// in order and rows bottom up within each column. The input side classifies
// an entry in the cycle it is taken and parks it in a descriptor queue (two
// deep by default), so new entries keep flowing while the sequencer works
// until the queue fills; the sequencer picks up the next queued entry in the
// same cycle it sends the last tile of the current one, and dropped entries
// use no output time. front_pass is written through cfg_wen/cfg_wdata and
// should only change while the block is idle.
`default_nettype none

module sprite_entry_tile_expander
    import sete_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // front_pass register write
    input  wire logic                  cfg_wen,
    input  wire logic                  cfg_wdata,
    // Sprite entry in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] y_word, [31:16] tile_word, [39:32] attr_byte,
    // [47:40] flip_byte, [63:48] x_word
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Tile commands out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] tile_index, [21:16] colour, [22] flip_x, [23] flip_y,
    // [34:24] x_pos, [44:35] y_pos, [47:45] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    // Classified entry heading into the queue
    desc_t push_desc;
    desc_t pop_desc;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;

    // Accept, filter and precompute start positions
    sete_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_desc        (push_desc)
    );

    // Decouple entry intake from tile emission
    sete_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_desc  (pop_desc)
    );

    // Walk columns and rows, one tile command per cycle unless the output stalls
    sete_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_desc        (pop_desc),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> tb/sprite_entry_tile_expander_tb.sv
`default_nettype none

module sprite_entry_tile_expander_tb;
    import sete_pkg::IN_DATA_W;
    import sete_pkg::OUT_DATA_W;

    localparam int CYCLE_LIMIT      = 1_500_000;
    localparam int LONG_HOLD_CYCLES = 400;
    // Cycles to let the block settle once nothing more is expected
    localparam int SETTLE_CYCLES    = 30;
    localparam int PHASE_KEPT       = 68;

    // Expected tile commands, built from each accepted sprite entry, and the
    // comparison of every command that leaves the block against them.
    class tile_cmd_board;
        typedef struct packed {
            logic [15:0] tile_index;
            logic [5:0]  colour;
            logic        flip_x;
            logic        flip_y;
            logic [10:0] x_pos;
            logic [9:0]  y_pos;
            logic        last;
        } tile_cmd_t;

        tile_cmd_t pending_cmds[$];
        logic      front_pass = 1'b0;
        int        mismatches = 0;

        // Expand one entry into its tile commands; return how many it makes.
        function int expand_entry(logic [IN_DATA_W-1:0] d);
            logic [15:0] y_word;
            logic [14:0] base;
            logic [7:0]  attr;
            logic [7:0]  flip;
            logic [8:0]  x9;
            logic [8:0]  y9;
            int          rows;
            int          cols;
            int          x;
            int          y;
            int          roff;
            tile_cmd_t   c;
            y_word = d[15:0];
            base   = d[30:16];
            attr   = d[39:32];
            flip   = d[47:40];
            x9     = d[56:48];
            y9     = y_word[8:0];
            // Drop on wrong pass or on a zero coordinate
            if (attr[7] != front_pass || x9 == 9'd0 || y9 == 9'd0)
                return 0;
            rows = 1 << y_word[10:9];
            cols = 1 << y_word[12:11];
            x = int'(x9) - 16;
            y = 496 - int'(y9);
            // A flipped sprite starts one tile to the right, unless it is one column wide
            if (flip[0] && cols > 1)
                x += 16;
            for (int j = 0; j < cols; j++)
            begin
                for (int i = 0; i < rows; i++)
                begin
                    roff = flip[1] ? i : rows - 1 - i;
                    c.tile_index = 16'(int'(base) + 8 * j + roff);
                    c.colour     = attr[5:0];
                    c.flip_x     = flip[0];
                    c.flip_y     = flip[1];
                    c.x_pos      = 11'(x);
                    c.y_pos      = 10'(y - 16 * i);
                    c.last       = (j == cols - 1) && (i == rows - 1);
                    pending_cmds.push_back(c);
                end
                x = flip[0] ? x - 16 : x + 16;
            end
            return rows * cols;
        endfunction

        function void match_tile_cmd(logic [OUT_DATA_W-1:0] d, logic tlast);
            tile_cmd_t got;
            tile_cmd_t want;
            got.tile_index = d[15:0];
            got.colour     = d[21:16];
            got.flip_x     = d[22];
            got.flip_y     = d[23];
            got.x_pos      = d[34:24];
            got.y_pos      = d[44:35];
            got.last       = tlast;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: tile command with nothing expected: tdata=%h tlast=%b",
                             $realtime, d, tlast);
                return;
            end
            want = pending_cmds.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: tile command mismatch: exp tile=%h col=%0d fx=%b fy=%b ",
                              "x=%0d y=%0d last=%b / got tile=%h col=%0d fx=%b fy=%b ",
                              "x=%0d y=%0d last=%b"}, $realtime,
                             want.tile_index, want.colour, want.flip_x, want.flip_y,
                             $signed(want.x_pos), $signed(want.y_pos), want.last,
                             got.tile_index, got.colour, got.flip_x, got.flip_y,
                             $signed(got.x_pos), $signed(got.y_pos), got.last);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wen;
    logic                  cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] y_word, [31:16] tile_word, [39:32] attr_byte,
    // [47:40] flip_byte, [63:48] x_word
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [15:0] tile_index, [21:16] colour, [22] flip_x, [23] flip_y,
    // [34:24] x_pos, [44:35] y_pos, [47:45] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    tile_cmd_board board = new;

    // Idling controls shared between the stimulus and the receiver
    logic tx_idle_on   = 1'b0;
    logic rx_idle_on   = 1'b0;
    logic long_hold_req = 1'b0;
    int   cycle_count  = 0;

    sprite_entry_tile_expander i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a run that hangs, e.g. on a lost tile command
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[sprite_entry_tile_expander] ERROR");
            $finish;
        end
    end

    // Check every tile command transaction against the oldest expectation.
    // Sampling right at the edge sees the values that were valid before it.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
            board.match_tile_cmd(m_axis_tdata, m_axis_tlast);
    end

    // Receiver: accept by default, drop tready in short random bursts while
    // idling is enabled, and hold off for a long stretch once when asked, so
    // that the descriptor queue fills and the block stalls its input.
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_entry(logic [15:0] y_word,
                                                        logic [15:0] tile_word,
                                                        logic [7:0] attr_byte,
                                                        logic [7:0] flip_byte,
                                                        logic [15:0] x_word);
        return {x_word, flip_byte, attr_byte, tile_word, y_word};
    endfunction

    // y_word from its fields: y, height exponent, width exponent
    function automatic logic [15:0] y_field(logic [8:0] y9, logic [1:0] hexp, logic [1:0] wexp);
        return {3'b000, wexp, hexp, y9};
    endfunction

    // Favor small sprites; only some reach the full 8 by 8
    function automatic logic [1:0] pick_exp();
        if ($urandom_range(0, 9) < 7)
            return 2'($urandom_range(0, 1));
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic logic [8:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 9'd1;
            1: return 9'd511;
            default: return 9'($urandom_range(1, 511));
        endcase
    endfunction

    // Mostly entries that draw on the current pass, with random content in
    // the ignored bits; some broken ones (zero coordinate, wrong pass) and
    // some raw noise.
    function automatic logic [IN_DATA_W-1:0] random_entry(logic pass);
        logic [15:0] y_word;
        logic [15:0] x_word;
        logic [7:0]  attr;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick >= 18)
            return {$urandom, $urandom};
        y_word = {3'($urandom), pick_exp(), pick_exp(), pick_coord()};
        x_word = {7'($urandom), pick_coord()};
        attr   = {pass, 7'($urandom)};
        if (pick == 15)
            y_word[8:0] = 9'd0;
        else if (pick == 16)
            x_word[8:0] = 9'd0;
        else if (pick == 17)
            attr[7] = ~pass;
        return pack_entry(y_word, 16'($urandom), attr, 8'($urandom), x_word);
    endfunction

    // Offer one entry and hold it until the block takes it; note the
    // expected commands at the accepting edge. tvalid stays high afterwards.
    task automatic send_entry(input logic [IN_DATA_W-1:0] d, output int cmds);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        cmds = board.expand_entry(d);
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop offering and wait until every expected command has arrived
    task automatic wait_drained();
        idle_sender(1);
        while (board.pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    // Change the pass only while idle; let dropped entries clear first
    task automatic write_front_pass(input logic value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        board.front_pass = value;
    endtask

    task automatic send_list(input logic [IN_DATA_W-1:0] list[$]);
        int cmds;
        foreach (list[k])
            send_entry(list[k], cmds);
    endtask

    initial
    begin
        logic [IN_DATA_W-1:0] directed[$];
        logic [IN_DATA_W-1:0] d;
        logic                 pass;
        int                   cmds;
        int                   kept;
        int                   n;

        rst_n         <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed entries on the normal pass (priority bit clear)
        directed = '{
            // full 8 by 8 in every flip combination
            pack_entry(y_field(9'd100, 2'd3, 2'd3), 16'h0100, 8'h05, 8'h00, 16'd200),
            pack_entry(y_field(9'd100, 2'd3, 2'd3), 16'h0200, 8'h06, 8'h01, 16'd200),
            pack_entry(y_field(9'd100, 2'd3, 2'd3), 16'h0300, 8'h07, 8'h02, 16'd200),
            // largest tile code, with the unused top bit of tile_word set
            pack_entry(y_field(9'd300, 2'd3, 2'd3), 16'hffff, 8'h3f, 8'h03, 16'd400),
            // flipped wide sprite at the left edge runs well below -16
            pack_entry(y_field(9'd50, 2'd0, 2'd3), 16'h0010, 8'h01, 8'h01, 16'd1),
            // coordinate extremes
            pack_entry(y_field(9'd1, 2'd0, 2'd0), 16'h0000, 8'h00, 8'h00, 16'd511),
            pack_entry(y_field(9'd511, 2'd0, 2'd0), 16'h1234, 8'h2a, 8'h00, 16'd1),
            pack_entry(y_field(9'd511, 2'd3, 2'd3), 16'h4000, 8'h15, 8'h00, 16'd511),
            // dropped: zero x, zero y, wrong pass, zero x with high bits set
            pack_entry(y_field(9'd20, 2'd1, 2'd1), 16'h0020, 8'h00, 8'h00, 16'd0),
            pack_entry(y_field(9'd0, 2'd1, 2'd1), 16'h0020, 8'h00, 8'h00, 16'd30),
            pack_entry(y_field(9'd20, 2'd1, 2'd1), 16'h0020, 8'h80, 8'h00, 16'd30),
            pack_entry(16'hffff & ~16'h01ff, 16'h0020, 8'h00, 8'h00, 16'hfe00),
            // flipped single column keeps its start position
            pack_entry(y_field(9'd80, 2'd2, 2'd0), 16'h0040, 8'h0c, 8'h01, 16'd90),
            // ignored bits all set
            pack_entry(16'he000 | y_field(9'd64, 2'd1, 2'd1), 16'h0050, 8'h7f, 8'hfc,
                       16'hfe00 | 16'd64),
            // mixed shapes
            pack_entry(y_field(9'd200, 2'd0, 2'd1), 16'h0060, 8'h02, 8'h01, 16'd100),
            pack_entry(y_field(9'd200, 2'd1, 2'd2), 16'h0070, 8'h03, 8'h02, 16'd100),
            pack_entry(y_field(9'd200, 2'd3, 2'd0), 16'h0080, 8'h04, 8'h03, 16'd100)
        };
        send_list(directed);

        // Front pass: priority set now draws, priority clear drops
        write_front_pass(1'b1);
        directed = '{
            pack_entry(y_field(9'd150, 2'd1, 2'd1), 16'h0400, 8'hbf, 8'h00, 16'd150),
            pack_entry(y_field(9'd150, 2'd1, 2'd1), 16'h0400, 8'h3f, 8'h00, 16'd150),
            pack_entry(y_field(9'd10, 2'd3, 2'd3), 16'h7fc0, 8'hc1, 8'h03, 16'd3)
        };
        send_list(directed);

        // Random phases, alternating the pass; the last phase runs at full rate
        for (int phase = 0; phase < 4; phase++)
        begin
            pass = phase[0];
            write_front_pass(pass);
            kept = 0;
            n = 0;
            while (kept < PHASE_KEPT)
            begin
                // Switch idling on and off in stretches
                if (n % 20 == 0)
                begin
                    tx_idle_on = (phase != 3) && $urandom_range(0, 3) != 0;
                    rx_idle_on = (phase != 3) && $urandom_range(0, 3) != 0;
                end
                if (phase == 1 && n == 30)
                    long_hold_req = 1'b1;
                if (phase == 2 && n == 40)
                    wait_drained();
                d = random_entry(pass);
                send_entry(d, cmds);
                if (cmds > 0)
                    kept++;
                n++;
                if (tx_idle_on && $urandom_range(0, 4) == 0)
                    idle_sender($urandom_range(1, 12));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_cmds.size() == 0)
            $display("[sprite_entry_tile_expander] OK");
        else
            $display("[sprite_entry_tile_expander] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
